// ----- rtl/ihx_pkg.sv -----
// Shared types and constants for the Intel HEX image loader.
package ihx_pkg;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_END     = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_PARSING = 3'd0,
        STAT_DONE    = 3'd1,
        STAT_BADHEX  = 3'd2,
        STAT_CKSUM   = 3'd3,
        STAT_RANGE   = 3'd4,
        STAT_TRUNC   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_BYTE,
        S_FULL,
        S_CRD,
        S_CWR,
        S_BASE0,
        S_BASE1,
        S_BASE2,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [14:0] read_addr;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  read_data;
        logic [15:0] used_length;
    } out_t;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_EOF    = 8'h01;
    localparam logic [7:0] REC_SEG    = 8'h02;
    localparam logic [7:0] REC_LIN    = 8'h04;

endpackage

// ----- rtl/ihx_hex_digit.sv -----
// ASCII hex digit decoder.
module ihx_hex_digit (
    input  logic [7:0] ch,
    output logic       digit_ok,
    output logic [3:0] digit_val
);
    logic [7:0] diff;

    always_comb begin
        diff      = 8'h00;
        digit_ok  = 1'b0;
        digit_val = 4'h0;
        priority if (ch >= 8'h30 && ch <= 8'h39) begin
            diff      = ch - 8'h30;
            digit_ok  = 1'b1;
            digit_val = diff[3:0];
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff      = ch - 8'h57;
            digit_ok  = 1'b1;
            digit_val = diff[3:0];
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff      = ch - 8'h37;
            digit_ok  = 1'b1;
            digit_val = diff[3:0];
        end else begin
            digit_ok  = 1'b0;
        end
    end
endmodule

// ----- rtl/ihx_alu.sv -----
// Shared 32-bit adder with a compare against the image size.
module ihx_alu #(
    parameter int LIMIT = 32768
) (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] sum,
    output logic        ge_limit
);
    assign sum      = op_a + op_b;
    // The sum wraps at 32 bits before it is compared.
    assign ge_limit = (sum >= 32'(LIMIT));
endmodule

// ----- rtl/intel_hex_image_loader_unit.sv -----
// Top level of the Intel HEX image loader: sequencer, record buffer and image store.
//
// Usage: each input transaction on s_valid/s_ready carries one operation: a
// character of the HEX text, end of source, an image byte read or a restart.
// Every input transaction yields exactly one result transaction on
// m_valid/m_ready holding the sticky status, the read byte (zero unless the
// operation was a read) and the highest written address plus one.
// Flow: a plain character or control operation passes through an execute step and
// a response step; a character that completes a byte adds a byte step. A record
// checksum character adds, for a data record, an address step and then one buffer
// read and one image write per data byte (address through the shared adder), or,
// for an address base record, the base steps S_BASE0 to S_BASE2.
// The block takes one transaction at a time; s_ready is high only while idle, so
// the next transaction waits until the current one has handed over its result.
// After reset the image store is filled with 0xFF, one byte per cycle, and
// s_ready stays low until the fill is complete.
// A result that is not yet taken holds in the output register; the block
// may accept and work on the next transaction meanwhile, but it waits
// before overwriting the pending result until m_ready is seen.
module intel_hex_image_loader_unit #(
    parameter int IMAGE_BYTES  = 32768,
    parameter int RECORD_BYTES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ihx_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ihx_pkg::out_t m_data
);
    import ihx_pkg::*;

    localparam int AW = $clog2(IMAGE_BYTES);
    localparam int HW = $clog2(IMAGE_BYTES + 1);
    localparam int RW = $clog2(RECORD_BYTES);

    // Sequencer and parse state.
    state_t      state_reg,  state_next;
    op_t         op_reg,     op_next;
    logic [7:0]  ch_reg,     ch_next;
    logic [14:0] raddr_reg,  raddr_next;
    logic        phase_reg,  phase_next;
    logic [9:0]  digit_reg,  digit_next;
    logic [7:0]  len_reg,    len_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [3:0]  hnib_reg,   hnib_next;
    logic [7:0]  byte_reg,   byte_next;
    logic [7:0]  cidx_reg,   cidx_next;
    logic [31:0] base_reg,   base_next;
    logic [31:0] full_reg,   full_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic        oor_reg,    oor_next;
    logic [HW-1:0] high_reg, high_next;
    status_t     status_reg, status_next;
    logic [7:0]  bhi_reg,    bhi_next;
    logic [AW-1:0] clr_reg,  clr_next;
    logic        rdok_reg,   rdok_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg,  m_data_next;

    // Memory ports.
    logic [7:0]    img_mem [IMAGE_BYTES];
    logic          img_we;
    logic [AW-1:0] img_waddr;
    logic [7:0]    img_wdata;
    logic          img_re;
    logic [AW-1:0] img_raddr;
    logic [7:0]    img_rdata_reg;

    logic [7:0]    buf_mem [RECORD_BYTES];
    logic          buf_we;
    logic [RW-1:0] buf_waddr;
    logic [7:0]    buf_wdata;
    logic [RW-1:0] buf_raddr;
    logic [7:0]    buf_rdata_reg;

    // Shared adder operands.
    logic [31:0] alu_a, alu_b, alu_sum;
    logic        alu_ge;

    logic       digit_ok;
    logic [3:0] digit_val;

    // Helpers for the byte and result paths.
    logic [8:0]    idx;
    logic [8:0]    pos;
    logic [7:0]    sum_new;
    logic [HW-1:0] high_cand;
    logic [31:0]   ra32;
    logic [31:0]   high32;
    logic [15:0]   vword;

    ihx_hex_digit u_digit (
        .ch        (ch_reg),
        .digit_ok  (digit_ok),
        .digit_val (digit_val)
    );

    ihx_alu #(
        .LIMIT (IMAGE_BYTES)
    ) u_alu (
        .op_a     (alu_a),
        .op_b     (alu_b),
        .sum      (alu_sum),
        .ge_limit (alu_ge)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign idx       = digit_reg[9:1];
    assign pos       = idx - 9'd4;
    assign sum_new   = alu_sum[7:0];
    assign high_cand = HW'(addr_reg) + HW'(1);
    assign ra32      = 32'(raddr_reg);
    assign high32    = 32'(high_reg);
    assign vword     = {bhi_reg, buf_rdata_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            phase_reg   <= 1'b0;
            digit_reg   <= '0;
            len_reg     <= '0;
            offset_reg  <= '0;
            type_reg    <= '0;
            sum_reg     <= '0;
            hnib_reg    <= '0;
            cidx_reg    <= '0;
            base_reg    <= '0;
            high_reg    <= '0;
            status_reg  <= STAT_PARSING;
            clr_reg     <= '0;
            rdok_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            digit_reg   <= digit_next;
            len_reg     <= len_next;
            offset_reg  <= offset_next;
            type_reg    <= type_next;
            sum_reg     <= sum_next;
            hnib_reg    <= hnib_next;
            cidx_reg    <= cidx_next;
            base_reg    <= base_next;
            high_reg    <= high_next;
            status_reg  <= status_next;
            clr_reg     <= clr_next;
            rdok_reg    <= rdok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        raddr_reg  <= raddr_next;
        byte_reg   <= byte_next;
        full_reg   <= full_next;
        addr_reg   <= addr_next;
        oor_reg    <= oor_next;
        bhi_reg    <= bhi_next;
        m_data_reg <= m_data_next;
    end

    // Image store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (img_we) begin
            img_mem[img_waddr] <= img_wdata;
        end
        if (img_re) begin
            img_rdata_reg <= img_mem[img_raddr];
        end
    end

    // Record buffer: written while the data field streams in, read during commit and for address base records.
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        ch_next      = ch_reg;
        raddr_next   = raddr_reg;
        phase_next   = phase_reg;
        digit_next   = digit_reg;
        len_next     = len_reg;
        offset_next  = offset_reg;
        type_next    = type_reg;
        sum_next     = sum_reg;
        hnib_next    = hnib_reg;
        byte_next    = byte_reg;
        cidx_next    = cidx_reg;
        base_next    = base_reg;
        full_next    = full_reg;
        addr_next    = addr_reg;
        oor_next     = oor_reg;
        high_next    = high_reg;
        status_next  = status_reg;
        bhi_next     = bhi_reg;
        clr_next     = clr_reg;
        rdok_next    = rdok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        img_we    = 1'b0;
        img_waddr = addr_reg;
        img_wdata = buf_rdata_reg;
        img_re    = 1'b0;
        img_raddr = ra32[AW-1:0];
        buf_we    = 1'b0;
        buf_waddr = pos[RW-1:0];
        buf_wdata = byte_reg;
        buf_raddr = cidx_reg[RW-1:0];

        alu_a = 32'(sum_reg);
        alu_b = 32'(byte_reg);

        unique case (state_reg)
            S_CLEAR: begin
                // Fill the image with erased bytes after reset.
                img_we    = 1'b1;
                img_waddr = clr_reg;
                img_wdata = 8'hFF;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(IMAGE_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.op;
                    ch_next    = s_data.ch;
                    raddr_next = s_data.read_addr;
                    rdok_next  = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next = S_RESP;
                unique case (op_reg)
                    OP_CHAR: begin
                        if (status_reg == STAT_PARSING) begin
                            priority if (!phase_reg) begin
                                if (ch_reg == CHAR_COLON) begin
                                    phase_next  = 1'b1;
                                    digit_next  = '0;
                                    sum_next    = '0;
                                    len_next    = '0;
                                    offset_next = '0;
                                    type_next   = '0;
                                end
                            end else if (!digit_ok) begin
                                status_next = STAT_BADHEX;
                            end else if (!digit_reg[0]) begin
                                hnib_next  = digit_val;
                                digit_next = digit_reg + 10'd1;
                            end else begin
                                byte_next  = {hnib_reg, digit_val};
                                state_next = S_BYTE;
                            end
                        end
                    end
                    OP_END: begin
                        if (status_reg == STAT_PARSING) begin
                            status_next = phase_reg ? STAT_TRUNC : STAT_DONE;
                        end
                    end
                    OP_READ: begin
                        rdok_next = (ra32 < 32'(IMAGE_BYTES));
                        img_re    = (ra32 < 32'(IMAGE_BYTES));
                    end
                    OP_RESTART: begin
                        phase_next  = 1'b0;
                        digit_next  = '0;
                        len_next    = '0;
                        offset_next = '0;
                        type_next   = '0;
                        sum_next    = '0;
                        hnib_next   = '0;
                        cidx_next   = '0;
                        base_next   = '0;
                        high_next   = '0;
                        status_next = STAT_PARSING;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_BYTE: begin
                // The adder accumulates the record checksum.
                sum_next   = sum_new;
                digit_next = digit_reg + 10'd1;
                state_next = S_RESP;
                priority if (idx == 9'd0) begin
                    len_next = byte_reg;
                    if ({1'b0, byte_reg} > 9'(RECORD_BYTES)) begin
                        status_next = STAT_TRUNC;
                    end
                end else if (idx == 9'd1) begin
                    offset_next = {byte_reg, 8'h00};
                end else if (idx == 9'd2) begin
                    offset_next = {offset_reg[15:8], byte_reg};
                end else if (idx == 9'd3) begin
                    type_next = byte_reg;
                end else if (pos < {1'b0, len_reg}) begin
                    buf_we = (pos < 9'(RECORD_BYTES));
                end else begin
                    // Checksum byte closes the record.
                    phase_next = 1'b0;
                    priority if (sum_new != 8'h00) begin
                        status_next = STAT_CKSUM;
                    end else if (type_reg == REC_DATA) begin
                        state_next = S_FULL;
                    end else if (type_reg == REC_EOF) begin
                        status_next = STAT_DONE;
                    end else if ((type_reg == REC_SEG || type_reg == REC_LIN)
                                 && len_reg == 8'd2) begin
                        state_next = S_BASE0;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end

            S_FULL: begin
                alu_a      = base_reg;
                alu_b      = 32'(offset_reg);
                full_next  = alu_sum;
                cidx_next  = '0;
                state_next = (len_reg == 8'd0) ? S_RESP : S_CRD;
            end

            S_CRD: begin
                // Buffer read is issued and the byte address formed in parallel.
                alu_a      = full_reg;
                alu_b      = 32'(cidx_reg);
                addr_next  = alu_sum[AW-1:0];
                oor_next   = alu_ge;
                state_next = S_CWR;
            end

            S_CWR: begin
                if (oor_reg) begin
                    status_next = STAT_RANGE;
                    state_next  = S_RESP;
                end else begin
                    img_we = 1'b1;
                    if (high_cand > high_reg) begin
                        high_next = high_cand;
                    end
                    cidx_next = cidx_reg + 8'd1;
                    if ({1'b0, cidx_reg} + 9'd1 == {1'b0, len_reg}) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_CRD;
                    end
                end
            end

            S_BASE0: begin
                buf_raddr  = RW'(0);
                state_next = S_BASE1;
            end

            S_BASE1: begin
                buf_raddr  = RW'(1);
                bhi_next   = buf_rdata_reg;
                state_next = S_BASE2;
            end

            S_BASE2: begin
                if (type_reg == REC_SEG) begin
                    base_next = {12'h000, vword, 4'h0};
                end else begin
                    base_next = {vword, 16'h0000};
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.read_data = rdok_reg ? img_rdata_reg : 8'h00;
                    m_data_next.used_length =
                        (high32 > 32'h0000_FFFF) ? 16'hFFFF : high32[15:0];
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
